// File: hw/rtl/ftv_pkg.sv
// shared constants, types and handshake structs for the fit-to-view downscaler
// used by ftv_div and fit_to_view_nearest_downscaler; depends on nothing
package ftv_pkg;

	localparam int FTV_MAX_DIM = 4096;
	localparam int FTV_MARGIN  = 12;

	localparam int DIM_W  = 13;
	localparam int VIEW_W = 14;
	localparam int PROD_W = DIM_W + VIEW_W;
	localparam int PIX_W  = 8;
	localparam int POS_W  = 12;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] CFG_VIEW_WIDTH    = 2'd2;
	localparam logic [IDX_W-1:0] CFG_VIEW_HEIGHT   = 2'd3;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [DIM_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quotient;
		logic [DIM_W-1:0]  remainder;
	} div_rsp_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic             last;
	} result_t;

endpackage

// File: hw/rtl/ftv_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on ftv_pkg for widths and the request/response structs
module ftv_div (
	input  logic             clk,
	input  logic             arst_n,
	input  ftv_pkg::div_req_t req,
	output ftv_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(ftv_pkg::PROD_W + 1);

	logic                        run_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [ftv_pkg::PROD_W-1:0]  quo_q;
	logic [ftv_pkg::DIM_W-1:0]   rem_q;
	logic [ftv_pkg::DIM_W-1:0]   dsr_q;

	logic [ftv_pkg::DIM_W:0] trial;
	logic                    take;

	assign trial = {rem_q, quo_q[ftv_pkg::PROD_W-1]};
	assign take  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(ftv_pkg::PROD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[ftv_pkg::PROD_W-2:0], take};
			if (take) begin
				rem_q <= ftv_pkg::DIM_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[ftv_pkg::DIM_W-1:0];
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// File: hw/rtl/fit_to_view_nearest_downscaler.sv
// fit-to-view nearest-neighbor downscaler, top level; depends on ftv_pkg and ftv_div
// a selected pixel enters the result queue on its input transfer
// throughput: one source pixel per cycle while not stalled; a two-entry result queue
//   decouples the sides; after a register write the preview size and step ratios are
//   set up by a shared serial divider, during which input is stalled
// reset: source 1x1, canvas 0x0, so the preview is empty and no setup pass is needed
module fit_to_view_nearest_downscaler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [ftv_pkg::IDX_W-1:0]   cfg_index,
	input  logic [ftv_pkg::VIEW_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ftv_pkg::PIX_W-1:0]   red_in,
	input  logic [ftv_pkg::PIX_W-1:0]   green_in,
	input  logic [ftv_pkg::PIX_W-1:0]   blue_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ftv_pkg::PIX_W-1:0]   red_out,
	output logic [ftv_pkg::PIX_W-1:0]   green_out,
	output logic [ftv_pkg::PIX_W-1:0]   blue_out,
	output logic [ftv_pkg::POS_W-1:0]   preview_x,
	output logic [ftv_pkg::POS_W-1:0]   preview_y,
	output logic                        frame_last
);

	localparam int DW = ftv_pkg::DIM_W;
	localparam int VW = ftv_pkg::VIEW_W;
	localparam int PW = ftv_pkg::PROD_W;

	localparam logic [VW:0] MAX_DIM_V = (VW+1)'(ftv_pkg::FTV_MAX_DIM);
	localparam logic [VW:0] MARGIN2_V = (VW+1)'(2 * ftv_pkg::FTV_MARGIN);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_AREA   = 4'd1;
	localparam logic [3:0] ST_MUL    = 4'd2;
	localparam logic [3:0] ST_DECIDE = 4'd3;
	localparam logic [3:0] ST_SIDE   = 4'd4;
	localparam logic [3:0] ST_COL_GO = 4'd5;
	localparam logic [3:0] ST_COL    = 4'd6;
	localparam logic [3:0] ST_ROW_GO = 4'd7;
	localparam logic [3:0] ST_ROW    = 4'd8;

	// configuration registers
	logic [DW-1:0] src_width_q, src_height_q;
	logic [VW-1:0] view_width_q, view_height_q;

	// setup state
	logic [3:0]    state_q;
	logic [DW-1:0] sw_q, sh_q, tw_q, th_q;
	logic [VW-1:0] aw_q, ah_q;
	logic          area_ok_q;
	logic [PW-1:0] prod_w_q, prod_h_q;
	logic          limit_w_q;
	logic [DW-1:0] col_step_q, col_frac_step_q, row_step_q, row_frac_step_q;

	ftv_pkg::div_req_t div_req;
	ftv_pkg::div_rsp_t div_rsp;

	logic [DW-1:0] sw_clamp, sh_clamp, quo_min1;
	logic          fits, width_limit, busy;

	// frame counters
	logic [DW-1:0] src_col_q, src_row_q, prev_col_q, prev_row_q;
	logic [DW-1:0] want_col_q, col_frac_q, want_row_q, row_frac_q;

	// result queue
	logic [1:0]        fifo_cnt_q;
	ftv_pkg::result_t  ent0_q, ent1_q, res_new;

	logic          in_xfer, out_xfer, col_hit, row_hit, line_end, last_row;
	logic [DW:0]   col_frac_sum, row_frac_sum;
	logic          col_wrap, row_wrap;
	logic [DW-1:0] col_frac_nxt, row_frac_nxt, want_col_nxt, want_row_nxt;

	ftv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q   <= DW'(1);
			src_height_q  <= DW'(1);
			view_width_q  <= '0;
			view_height_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ftv_pkg::CFG_SOURCE_WIDTH:  src_width_q   <= cfg_data[DW-1:0];
				ftv_pkg::CFG_SOURCE_HEIGHT: src_height_q  <= cfg_data[DW-1:0];
				ftv_pkg::CFG_VIEW_WIDTH:    view_width_q  <= cfg_data;
				ftv_pkg::CFG_VIEW_HEIGHT:   view_height_q <= cfg_data;
			endcase
		end
	end

	// source size clamped to 1..max
	always_comb begin
		if (src_width_q == '0) begin
			sw_clamp = DW'(1);
		end else if ({2'b00, src_width_q} > MAX_DIM_V) begin
			sw_clamp = MAX_DIM_V[DW-1:0];
		end else begin
			sw_clamp = src_width_q;
		end
		if (src_height_q == '0) begin
			sh_clamp = DW'(1);
		end else if ({2'b00, src_height_q} > MAX_DIM_V) begin
			sh_clamp = MAX_DIM_V[DW-1:0];
		end else begin
			sh_clamp = src_height_q;
		end
	end

	assign fits        = !(({1'b0, sw_q} > aw_q) || ({1'b0, sh_q} > ah_q));
	assign width_limit = prod_w_q <= prod_h_q;
	assign quo_min1    = (div_rsp.quotient == '0) ? DW'(1) : div_rsp.quotient[DW-1:0];
	assign busy        = state_q != ST_IDLE;

	always_comb begin
		div_req = '0;
		if (state_q == ST_DECIDE && area_ok_q && !fits) begin
			div_req.start    = 1'b1;
			div_req.dividend = width_limit ? prod_w_q : prod_h_q;
			div_req.divisor  = width_limit ? sw_q : sh_q;
		end else if (state_q == ST_COL_GO) begin
			div_req.start    = 1'b1;
			div_req.dividend = PW'(sw_q);
			div_req.divisor  = tw_q;
		end else if (state_q == ST_ROW_GO) begin
			div_req.start    = 1'b1;
			div_req.dividend = PW'(sh_q);
			div_req.divisor  = th_q;
		end
	end

	// setup sequencer: area, products, size decision, then up to three divisions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sw_q    <= DW'(1);
			sh_q    <= DW'(1);
			tw_q    <= '0;
			th_q    <= '0;
		end else if (cfg_write) begin
			state_q <= ST_AREA;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_AREA: begin
					sw_q    <= sw_clamp;
					sh_q    <= sh_clamp;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (!area_ok_q) begin
						tw_q    <= '0;
						th_q    <= '0;
						state_q <= ST_IDLE;
					end else if (fits) begin
						tw_q    <= sw_q;
						th_q    <= sh_q;
						state_q <= ST_COL_GO;
					end else if (width_limit) begin
						tw_q    <= aw_q[DW-1:0];
						state_q <= ST_SIDE;
					end else begin
						th_q    <= ah_q[DW-1:0];
						state_q <= ST_SIDE;
					end
				end
				ST_SIDE: begin
					if (div_rsp.done) begin
						if (limit_w_q) begin
							th_q <= quo_min1;
						end else begin
							tw_q <= quo_min1;
						end
						state_q <= ST_COL_GO;
					end
				end
				ST_COL_GO: state_q <= ST_COL;
				ST_COL: begin
					if (div_rsp.done) begin
						state_q <= ST_ROW_GO;
					end
				end
				ST_ROW_GO: state_q <= ST_ROW;
				ST_ROW: begin
					if (div_rsp.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_AREA) begin
			area_ok_q <= ({1'b0, view_width_q} > MARGIN2_V) &&
				({1'b0, view_height_q} > MARGIN2_V);
			aw_q <= VW'({1'b0, view_width_q} - MARGIN2_V);
			ah_q <= VW'({1'b0, view_height_q} - MARGIN2_V);
		end
		if (state_q == ST_MUL) begin
			prod_w_q <= PW'(aw_q) * PW'(sh_q);
			prod_h_q <= PW'(ah_q) * PW'(sw_q);
		end
		if (state_q == ST_DECIDE) begin
			limit_w_q <= width_limit;
		end
		if (state_q == ST_COL && div_rsp.done) begin
			col_step_q      <= div_rsp.quotient[DW-1:0];
			col_frac_step_q <= div_rsp.remainder;
		end
		if (state_q == ST_ROW && div_rsp.done) begin
			row_step_q      <= div_rsp.quotient[DW-1:0];
			row_frac_step_q <= div_rsp.remainder;
		end
	end

	// pixel selection
	assign in_stall = busy || cfg_write || (fifo_cnt_q == 2'd2);
	assign in_xfer  = in_valid && !in_stall;
	assign out_valid = fifo_cnt_q != 2'd0;
	assign out_xfer  = out_valid && !out_stall;

	assign row_hit  = (th_q != '0) && (prev_row_q < th_q) && (src_row_q == want_row_q);
	assign col_hit  = (tw_q != '0) && row_hit && (prev_col_q < tw_q) &&
		(src_col_q == want_col_q);
	assign line_end = ({1'b0, src_col_q} + (DW+1)'(1)) >= {1'b0, sw_q};
	assign last_row = ({1'b0, src_row_q} + (DW+1)'(1)) >= {1'b0, sh_q};

	// incremental floor(x*W/tw) and floor(y*H/th)
	assign col_frac_sum = {1'b0, col_frac_q} + {1'b0, col_frac_step_q};
	assign col_wrap     = col_frac_sum >= {1'b0, tw_q};
	assign col_frac_nxt = col_wrap ? DW'(col_frac_sum - {1'b0, tw_q}) : col_frac_sum[DW-1:0];
	assign want_col_nxt = want_col_q + col_step_q + DW'(col_wrap);

	assign row_frac_sum = {1'b0, row_frac_q} + {1'b0, row_frac_step_q};
	assign row_wrap     = row_frac_sum >= {1'b0, th_q};
	assign row_frac_nxt = row_wrap ? DW'(row_frac_sum - {1'b0, th_q}) : row_frac_sum[DW-1:0];
	assign want_row_nxt = want_row_q + row_step_q + DW'(row_wrap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q  <= '0;
			src_row_q  <= '0;
			prev_col_q <= '0;
			prev_row_q <= '0;
			want_col_q <= '0;
			col_frac_q <= '0;
			want_row_q <= '0;
			row_frac_q <= '0;
		end else if (cfg_write) begin
			src_col_q  <= '0;
			src_row_q  <= '0;
			prev_col_q <= '0;
			prev_row_q <= '0;
			want_col_q <= '0;
			col_frac_q <= '0;
			want_row_q <= '0;
			row_frac_q <= '0;
		end else if (in_xfer) begin
			if (line_end) begin
				src_col_q  <= '0;
				prev_col_q <= '0;
				want_col_q <= '0;
				col_frac_q <= '0;
				if (last_row) begin
					// frame wraps, next pixel starts a new frame
					src_row_q  <= '0;
					prev_row_q <= '0;
					want_row_q <= '0;
					row_frac_q <= '0;
				end else begin
					src_row_q <= src_row_q + DW'(1);
					if (row_hit) begin
						prev_row_q <= prev_row_q + DW'(1);
						want_row_q <= want_row_nxt;
						row_frac_q <= row_frac_nxt;
					end
				end
			end else begin
				src_col_q <= src_col_q + DW'(1);
				if (col_hit) begin
					prev_col_q <= prev_col_q + DW'(1);
					want_col_q <= want_col_nxt;
					col_frac_q <= col_frac_nxt;
				end
			end
		end
	end

	// result queue, head drives the outputs
	always_comb begin
		res_new.red   = red_in;
		res_new.green = green_in;
		res_new.blue  = blue_in;
		res_new.pos_x = prev_col_q[ftv_pkg::POS_W-1:0];
		res_new.pos_y = prev_row_q[ftv_pkg::POS_W-1:0];
		res_new.last  = (({1'b0, prev_col_q} + (DW+1)'(1)) == {1'b0, tw_q}) &&
			(({1'b0, prev_row_q} + (DW+1)'(1)) == {1'b0, th_q});
	end

	logic push;
	assign push = in_xfer && col_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_cnt_q <= '0;
		end else begin
			fifo_cnt_q <= fifo_cnt_q + 2'(push) - 2'(out_xfer);
		end
	end

	always_ff @(posedge clk) begin
		if (push && (fifo_cnt_q == 2'd0 || (fifo_cnt_q == 2'd1 && out_xfer))) begin
			ent0_q <= res_new;
		end else if (out_xfer) begin
			ent0_q <= ent1_q;
		end
		if (push && fifo_cnt_q == 2'd1 && !out_xfer) begin
			ent1_q <= res_new;
		end
	end

	assign red_out    = ent0_q.red;
	assign green_out  = ent0_q.green;
	assign blue_out   = ent0_q.blue;
	assign preview_x  = ent0_q.pos_x;
	assign preview_y  = ent0_q.pos_y;
	assign frame_last = ent0_q.last;

endmodule
